### src/stq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted timer queue.
// No dependencies; every other file of the block imports this package.
package stq_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TICK_BITS_DEF = 32;
  localparam int MAX_RESULTS   = 16;
  localparam int ID_W          = 4;
  localparam int ID_COUNT      = 16;
  localparam int KIND_W        = 3;
  localparam int FIELD_W       = 32;
  localparam int S_TDATA_W     = 40;
  localparam int M_TDATA_W     = 104;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_SCHED = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHED     = 3'd0,
    KIND_EXPIRED   = 3'd1,
    KIND_IDLE_TICK = 3'd2,
    KIND_DUP       = 3'd3,
    KIND_FULL      = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_TICK_CHECK,
    ST_POP,
    ST_LOAD_RD,
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_SCHED_EMIT,
    ST_REJECT
  } state_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_SHIFT,
    RD_HEAD
  } rd_sel_t;

  typedef enum logic {
    WR_SHIFT,
    WR_INSERT
  } wr_sel_t;

  typedef enum logic [1:0] {
    EM_PENDING,
    EM_IDLE_TICK,
    EM_SCHED,
    EM_REJECT
  } emit_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      cap_req;
    logic      tick_inc;
    logic      clr_n;
    logic      k_clr;
    logic      k_inc;
    logic      j_load;
    logic      j_dec;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    logic      insert;
    logic      pop;
    logic      load_head;
    logic      emit;
    emit_sel_t emit_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_sched;
    logic dup;
    logic full;
    logic len_zero;
    logic len_one;
    logic more;
    logic has_pend;
    logic past;
    logic scan_last;
    logic j_at_k;
    logic out_free;
  } sts_t;

endpackage

### src/sorted_timer_queue_unit.sv
`timescale 1ns / 1ps
// Sorted timer queue: a free-running tick counter and up to SLOTS timers held in
// deadline order in a single-port-read, single-port-write ring memory. A tick word
// (tuser 0) advances the count and reports every timer whose deadline has been
// reached, head first, at most 16 per tick, the final one marked by tlast; with
// none due it gives one "nothing expired" word. A schedule word (tuser 1) gives one
// result word. One request is handled at a time. The slot memory gives one read and
// one write per cycle; a stalled result word holds the block until the output is free.
// No clearing pass after reset: the queue starts empty.
// Depends on stq_pkg, stq_ctrl and stq_dp.
module sorted_timer_queue_unit #(
  parameter int SLOTS     = stq_pkg::SLOTS_DEF,
  parameter int TICK_BITS = stq_pkg::TICK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // timer_id [3:0], deadline [35:4], zero fill [39:36]
  input  logic [stq_pkg::S_TDATA_W-1:0] s_tdata,
  // req_type
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // timer_id_res [3:0], fire_time [35:4], now_ticks [67:36], queue_empty [68],
  // next_deadline [100:69], zero fill [103:101]
  output logic [stq_pkg::M_TDATA_W-1:0] m_tdata,
  // result_kind
  output logic [stq_pkg::KIND_W-1:0]    m_tuser,
  // last
  output logic                          m_tlast
);
  import stq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stq_dp #(
    .SLOTS     (SLOTS),
    .TICK_BITS (TICK_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### src/stq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the sorted timer queue: walks scan, shift, insert and expiry steps.
// Depends on stq_pkg; drives the datapath stq_dp through cmd_t and reads sts_t.
module stq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  stq_pkg::sts_t sts,
  output stq_pkg::cmd_t cmd
);
  import stq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.cap_req = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!sts.is_sched) begin
          cmd.tick_inc = 1'b1;
          cmd.clr_n    = 1'b1;
          state_next   = ST_TICK_CHECK;
        end else begin
          cmd.k_clr = 1'b1;
          if (sts.dup || sts.full) begin
            state_next = ST_REJECT;
          end else if (sts.len_zero) begin
            cmd.j_load = 1'b1;
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_TICK_CHECK: begin
        // a popped timer is reported only once the next head is known
        if (sts.has_pend) begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_PENDING;
            state_next   = sts.more ? ST_POP : ST_IDLE;
          end
        end else if (sts.more) begin
          state_next = ST_POP;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_IDLE_TICK;
          state_next   = ST_IDLE;
        end
      end
      ST_POP: begin
        cmd.pop    = 1'b1;
        state_next = sts.len_one ? ST_TICK_CHECK : ST_LOAD_RD;
      end
      ST_LOAD_RD: begin
        cmd.rd_sel = RD_HEAD;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_head = 1'b1;
        state_next    = ST_TICK_CHECK;
      end
      ST_SCAN_RD: begin
        cmd.rd_sel = RD_SCAN;
        state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts.past) begin
          cmd.k_inc = 1'b1;
          if (sts.scan_last) begin
            cmd.j_load = 1'b1;
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_SCAN_RD;
          end
        end else begin
          cmd.j_load = 1'b1;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        state_next = sts.j_at_k ? ST_INSERT : ST_SHIFT_RD;
      end
      ST_SHIFT_RD: begin
        cmd.rd_sel = RD_SHIFT;
        state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.j_dec  = 1'b1;
        state_next = ST_SHIFT;
      end
      ST_INSERT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_INSERT;
        cmd.insert = 1'b1;
        state_next = ST_SCHED_EMIT;
      end
      ST_SCHED_EMIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_SCHED;
          state_next   = ST_IDLE;
        end
      end
      ST_REJECT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_REJECT;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/stq_dp.sv
`timescale 1ns / 1ps
// Datapath of the sorted timer queue: tick counter, ring-buffer slot memory,
// head copy, queued flags and the output word register. Depends on stq_pkg.
module stq_dp #(
  parameter int SLOTS     = stq_pkg::SLOTS_DEF,
  parameter int TICK_BITS = stq_pkg::TICK_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  stq_pkg::cmd_t                  cmd,
  output stq_pkg::sts_t                  sts,
  input  logic [stq_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [stq_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [stq_pkg::KIND_W-1:0]     m_tuser,
  output logic                           m_tlast
);
  import stq_pkg::*;

  localparam int PW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int NW    = $clog2(MAX_RESULTS + 1);
  localparam int ENT_W = ID_W + TICK_BITS;

  // slot memory, ring addressed from head_ptr
  logic [ENT_W-1:0]     mem [SLOTS];
  logic [ENT_W-1:0]     rd_data;
  logic [PW-1:0]        raddr, waddr;
  logic [ENT_W-1:0]     wdata;

  logic [TICK_BITS-1:0] now_cnt;
  logic [PW-1:0]        head_ptr;
  logic [LW-1:0]        len;
  logic [ID_COUNT-1:0]  qflags;
  logic [TICK_BITS-1:0] head_dl;
  logic [ID_W-1:0]      head_id;
  logic [LW-1:0]        k, j;
  logic [NW-1:0]        n;
  logic [ID_W-1:0]      pend_id;
  logic [TICK_BITS-1:0] pend_dl;
  logic                 req_sched;
  logic [ID_W-1:0]      req_id;
  logic [TICK_BITS-1:0] req_dl;

  logic [TICK_BITS-1:0] scan_diff, head_diff;
  logic                 occurred;
  logic [LW-1:0]        roff, woff;
  logic [PW-1:0]        head_ptr_inc;

  logic [KIND_W-1:0]    em_kind;
  logic [ID_W-1:0]      em_id;
  logic [TICK_BITS-1:0] em_fire;
  logic                 em_last;

  function automatic logic [PW-1:0] ring_idx(input logic [PW-1:0] base,
                                             input logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PW+1)'(SLOTS)) begin
      sum = sum - (PW+1)'(SLOTS);
    end
    return sum[PW-1:0];
  endfunction

  // read and write offsets relative to the head
  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN:  roff = k;
      RD_SHIFT: roff = j - LW'(1);
      RD_HEAD:  roff = '0;
      default:  roff = '0;
    endcase
    woff  = (cmd.wr_sel == WR_SHIFT) ? j : k;
    wdata = (cmd.wr_sel == WR_SHIFT) ? rd_data : {req_id, req_dl};
    raddr = ring_idx(head_ptr, roff[PW-1:0]);
    waddr = ring_idx(head_ptr, woff[PW-1:0]);
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[raddr];
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // wraparound compares: past when the difference has its top bit set
  assign scan_diff    = rd_data[TICK_BITS-1:0] - req_dl;
  assign head_diff    = head_dl - now_cnt;
  assign occurred     = (head_dl == now_cnt) || head_diff[TICK_BITS-1];
  assign head_ptr_inc = (head_ptr == PW'(SLOTS - 1)) ? '0 : head_ptr + PW'(1);

  always_comb begin
    sts.is_sched  = req_sched;
    sts.dup       = qflags[req_id];
    sts.full      = (len == LW'(SLOTS));
    sts.len_zero  = (len == '0);
    sts.len_one   = (len == LW'(1));
    sts.more      = (len != '0) && occurred && (n < NW'(MAX_RESULTS));
    sts.has_pend  = (n != '0);
    sts.past      = scan_diff[TICK_BITS-1];
    sts.scan_last = ((k + LW'(1)) == len);
    sts.j_at_k    = (j == k);
    sts.out_free  = !m_tvalid || m_tready;
  end

  always_comb begin
    case (cmd.emit_sel)
      EM_PENDING: begin
        em_kind = KIND_EXPIRED;
        em_id   = pend_id;
        em_fire = pend_dl;
        em_last = !sts.more;
      end
      EM_IDLE_TICK: begin
        em_kind = KIND_IDLE_TICK;
        em_id   = '0;
        em_fire = '0;
        em_last = 1'b1;
      end
      EM_SCHED: begin
        em_kind = KIND_SCHED;
        em_id   = req_id;
        em_fire = req_dl;
        em_last = 1'b1;
      end
      EM_REJECT: begin
        em_kind = qflags[req_id] ? KIND_DUP : KIND_FULL;
        em_id   = req_id;
        em_fire = '0;
        em_last = 1'b1;
      end
      default: begin
        em_kind = KIND_IDLE_TICK;
        em_id   = '0;
        em_fire = '0;
        em_last = 1'b1;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      now_cnt  <= '0;
      head_ptr <= '0;
      len      <= '0;
      qflags   <= '0;
      n        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.tick_inc) begin
        now_cnt <= now_cnt + TICK_BITS'(1);
      end
      if (cmd.clr_n) begin
        n <= '0;
      end else if (cmd.pop) begin
        n <= n + NW'(1);
      end
      if (cmd.pop) begin
        head_ptr        <= head_ptr_inc;
        len             <= len - LW'(1);
        qflags[head_id] <= 1'b0;
      end else if (cmd.insert) begin
        len            <= len + LW'(1);
        qflags[req_id] <= 1'b1;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      req_sched <= s_tuser;
      req_id    <= s_tdata[ID_W-1:0];
      req_dl    <= TICK_BITS'(s_tdata[ID_W +: FIELD_W]);
    end
    if (cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + LW'(1);
    end
    if (cmd.j_load) begin
      j <= len;
    end else if (cmd.j_dec) begin
      j <= j - LW'(1);
    end
    if (cmd.pop) begin
      pend_id <= head_id;
      pend_dl <= head_dl;
    end
    if (cmd.insert && (k == '0)) begin
      head_dl <= req_dl;
      head_id <= req_id;
    end else if (cmd.load_head) begin
      head_dl <= rd_data[TICK_BITS-1:0];
      head_id <= rd_data[ENT_W-1:TICK_BITS];
    end
    if (cmd.emit) begin
      m_tuser <= em_kind;
      m_tlast <= em_last;
      m_tdata <= {3'b000,
                  (len == '0) ? FIELD_W'(0) : FIELD_W'(head_dl),
                  (len == '0),
                  FIELD_W'(now_cnt),
                  FIELD_W'(em_fire),
                  em_id};
    end
  end

endmodule

### src/stq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for sorted_timer_queue_unit, attached by the bind below.
// Depends on stq_pkg for the result kind codes.
module stq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [stq_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [stq_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [stq_pkg::KIND_W-1:0]    m_tuser,
  input logic                          m_tlast
);
  import stq_pkg::*;

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tready ^ s_tuser ^ (^s_tdata);

  // hold a stalled word
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  // empty queue shows a zero head deadline
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[68] |-> (m_tdata[100:69] == 32'd0))
    else $error("next_deadline not zero on empty queue");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_IDLE_TICK) |-> m_tlast && (m_tdata[35:0] == 36'd0))
    else $error("idle tick word malformed");

  // a schedule result word is always marked last
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == KIND_SCHED) || (m_tuser == KIND_DUP) ||
                 (m_tuser == KIND_FULL)) |-> m_tlast)
    else $error("schedule result not marked last");

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (.*);

### sim/sorted_timer_queue_unit_check.sv
`timescale 1ns / 1ps
// Scoreboard for the sorted timer queue: watches both stream channels, keeps its own
// tick count and deadline-ordered timer list, and compares every result word.
// Depends on stq_pkg.
module sorted_timer_queue_unit_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // timer_id [3:0], deadline [35:4], zero fill [39:36]
  input  logic [stq_pkg::S_TDATA_W-1:0] s_tdata,
  // req_type
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // timer_id_res [3:0], fire_time [35:4], now_ticks [67:36], queue_empty [68],
  // next_deadline [100:69], zero fill [103:101]
  input  logic [stq_pkg::M_TDATA_W-1:0] m_tdata,
  // result_kind
  input  logic [stq_pkg::KIND_W-1:0]    m_tuser,
  // last
  input  logic                          m_tlast,
  output int                            fail_count,
  output int                            pending
);
  import stq_pkg::*;

  localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;
  localparam int          MAX_PRINTS = 40;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  id;
    logic [31:0] fire;
    logic [31:0] now;
    logic        empty;
    logic [31:0] head;
    logic        last;
  } timer_report_t;

  logic [31:0]   tick_now;
  logic [31:0]   slot_dl [SLOTS_DEF];
  logic [3:0]    slot_id [SLOTS_DEF];
  int            depth;
  bit            armed [ID_COUNT];
  timer_report_t due_reports [$];

  // t lies behind base, by at most half the tick range
  function automatic bit overdue(input logic [31:0] t, input logic [31:0] base);
    logic [31:0] diff;
    diff = t - base;
    return diff > HALF_RANGE;
  endfunction

  function automatic bit reached(input logic [31:0] t, input logic [31:0] base);
    return (t == base) || overdue(t, base);
  endfunction

  task automatic report(input string what);
    if (fail_count < MAX_PRINTS) $display("%0t ns: %s", $time, what);
    fail_count++;
  endtask

  // Record a result as the block must show it, with the queue as it stands now
  task automatic note(input kind_t kind, input logic [3:0] id, input logic [31:0] fire,
                      input logic last);
    timer_report_t r;
    r.kind  = kind;
    r.id    = id;
    r.fire  = fire;
    r.now   = tick_now;
    r.empty = (depth == 0);
    r.head  = (depth == 0) ? 32'd0 : slot_dl[0];
    r.last  = last;
    due_reports.push_back(r);
  endtask

  task automatic predict_request(input logic req, input logic [3:0] id,
                                 input logic [31:0] dl);
    int          pos;
    int          i;
    int          n;
    bit          more;
    logic [3:0]  gone_id;
    logic [31:0] gone_dl;
    if (req == REQ_SCHED) begin
      if (armed[id]) begin
        note(KIND_DUP, id, 32'd0, 1'b1);
      end else if (depth >= SLOTS_DEF) begin
        note(KIND_FULL, id, 32'd0, 1'b1);
      end else begin
        // skip entries that lie behind the new deadline, then open a gap
        pos = 0;
        while (pos < depth && overdue(slot_dl[pos], dl)) pos++;
        for (i = depth; i > pos; i--) begin
          slot_dl[i] = slot_dl[i-1];
          slot_id[i] = slot_id[i-1];
        end
        slot_dl[pos] = dl;
        slot_id[pos] = id;
        depth++;
        armed[id] = 1'b1;
        note(KIND_SCHED, id, dl, 1'b1);
      end
    end else begin
      tick_now = tick_now + 32'd1;
      n = 0;
      more = (depth > 0) && reached(slot_dl[0], tick_now);
      if (!more) note(KIND_IDLE_TICK, 4'd0, 32'd0, 1'b1);
      while (more) begin
        gone_id = slot_id[0];
        gone_dl = slot_dl[0];
        for (i = 1; i < depth; i++) begin
          slot_dl[i-1] = slot_dl[i];
          slot_id[i-1] = slot_id[i];
        end
        depth--;
        armed[gone_id] = 1'b0;
        n++;
        more = (n < MAX_RESULTS) && (depth > 0) && reached(slot_dl[0], tick_now);
        note(KIND_EXPIRED, gone_id, gone_dl, !more);
      end
    end
  endtask

  task automatic check_word();
    timer_report_t want;
    if (due_reports.size() == 0) begin
      report($sformatf("unexpected result word: kind %0d id %0d", m_tuser, m_tdata[3:0]));
    end else begin
      want = due_reports.pop_front();
      if (m_tuser !== want.kind)
        report($sformatf("result_kind: got %0d, want %0d", m_tuser, want.kind));
      if (m_tdata[3:0] !== want.id)
        report($sformatf("timer_id_res: got %0d, want %0d", m_tdata[3:0], want.id));
      if (m_tdata[35:4] !== want.fire)
        report($sformatf("fire_time: got %h, want %h", m_tdata[35:4], want.fire));
      if (m_tdata[67:36] !== want.now)
        report($sformatf("now_ticks: got %h, want %h", m_tdata[67:36], want.now));
      if (m_tdata[68] !== want.empty)
        report($sformatf("queue_empty: got %b, want %b", m_tdata[68], want.empty));
      if (m_tdata[100:69] !== want.head)
        report($sformatf("next_deadline: got %h, want %h", m_tdata[100:69], want.head));
      if (m_tlast !== want.last)
        report($sformatf("last: got %b, want %b", m_tlast, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tick_now   = 32'd0;
      depth      = 0;
      fail_count = 0;
      for (int k = 0; k < ID_COUNT; k++) armed[k] = 1'b0;
      due_reports.delete();
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata[3:0], s_tdata[35:4]);
      if (m_tvalid && m_tready) check_word();
      pending <= due_reports.size();
    end
  end

endmodule

### sim/sorted_timer_queue_unit_test.sv
`timescale 1ns / 1ps
// Top of the sorted timer queue testbench: clock, reset, request stimulus in bursts,
// result back-pressure and the verdict.
// Depends on stq_pkg, sorted_timer_queue_unit and sorted_timer_queue_unit_check.
module sorted_timer_queue_unit_test;
  import stq_pkg::*;

  localparam int RANDOM_ITEMS = 360;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 100;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]    m_tuser;
  logic                 m_tlast;
  int                   fail_count;
  int                   pending;

  int          cycle_count  = 0;
  int          items_sent   = 0;
  int          burst_left   = 0;
  int          stuck_budget = 1;
  logic [31:0] ticks_sent   = 32'd0;
  logic [31:0] last_dl      = 32'd0;
  bit          hold_request = 1'b0;

  sorted_timer_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  sorted_timer_queue_unit_check watch (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_timer_queue_unit_test NOT OK");
      $finish;
    end
  end

  // Offer one word and hold it until taken; bursts end in a random gap, which may be zero
  task automatic send_request(input logic req, input logic [3:0] id,
                              input logic [31:0] dl);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {4'd0, dl, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (req == REQ_TICK) ticks_sent = ticks_sent + 32'd1;
    else last_dl = dl;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
                                               : $urandom_range(8, 0);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Deadlines relative to the current count: near future, due next tick, repeated,
  // behind, or, once, on the half-range boundary where a timer stays pending longest
  function automatic logic [31:0] pick_deadline();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return ticks_sent + $urandom_range(5, 1);
      4:          return ticks_sent;
      5:          return last_dl;
      6, 7, 8:    return ticks_sent + 32'h8000_0001 + ($urandom & 32'h7FFF_FFFF);
      default: begin
        if (stuck_budget > 0) begin
          stuck_budget--;
          return ticks_sent + 32'h7FFF_FFFF;
        end
        return ticks_sent + 32'd1;
      end
    endcase
  endfunction

  // Result side: segments of differing stall patterns, one long hold-off
  initial begin
    int seg_len;
    int mode;
    int c;
    bit held;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      seg_len = $urandom_range(200, 20);
      mode    = $urandom_range(3, 0);
      for (c = 0; c < seg_len; c++) begin
        if (hold_request && !held) begin
          held = 1'b1;
          m_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(1, 0);
          2:       m_tready <= ($urandom_range(9, 0) != 0);
          default: m_tready <= (c % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int          k;
    int          stop_at;
    logic [31:0] dl;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= REQ_TICK;
    s_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(REQ_TICK, 4'd0, 32'd0);            // nothing queued
    send_request(REQ_SCHED, 4'd0, 32'd3);
    send_request(REQ_SCHED, 4'd15, 32'd3);          // equal deadline goes ahead
    send_request(REQ_SCHED, 4'd5, 32'hFFFF_FFFF);   // already behind: lands at head
    send_request(REQ_TICK, 4'hF, 32'hFFFF_FFFF);
    send_request(REQ_TICK, 4'd0, 32'd0);            // two timers due together
    // fill every slot with timers all due on the next tick
    for (k = 0; k < ID_COUNT; k++) begin
      case (k)
        0:       dl = 32'd0;
        1:       dl = 32'hFFFF_FFFF;
        2:       dl = ticks_sent;
        3:       dl = ticks_sent + 32'h8000_0001;
        default: dl = ticks_sent + 32'd1;
      endcase
      send_request(REQ_SCHED, k[3:0], dl);
    end
    send_request(REQ_SCHED, 4'd3, 32'd0);           // already queued while full
    send_request(REQ_TICK, 4'd0, 32'd0);            // whole queue expires
    send_request(REQ_SCHED, 4'd9, ticks_sent + 32'h7FFF_FFFF);

    hold_request = 1'b1;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(9, 0) < 6) begin
        // schedule a batch, then tick it down
        repeat ($urandom_range(16, 1))
          send_request(REQ_SCHED, 4'($urandom_range(15, 0)), pick_deadline());
        repeat ($urandom_range(6, 1))
          send_request(REQ_TICK, 4'($urandom_range(15, 0)), $urandom);
      end else begin
        repeat ($urandom_range(10, 1)) begin
          if ($urandom_range(1, 0) == 1)
            send_request(REQ_SCHED, 4'($urandom_range(15, 0)), pick_deadline());
          else
            send_request(REQ_TICK, 4'($urandom_range(15, 0)), $urandom);
        end
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_timer_queue_unit_test OK");
    end else begin
      $display("sorted_timer_queue_unit_test NOT OK");
    end
    $finish;
  end

endmodule
